[sv/assert_macros.svh]
// Assertion macros shared by the queue modules.
// Each macro expects the enclosing module to have i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define SPQ_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[sv/spq_pkg.sv]
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;

    // Operation codes carried on the kind input.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] handle;
        logic [7:0]  item_type;
        logic [15:0] prio;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    scan_check;
        logic    rd_prev;
        logic    shift_write;
        logic    ins_write;
        logic    take_head;
        logic    set_res;
        t_status res_code;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic full;
        logic dup;
        logic scan_last;
        logic shift_done;
    } t_dp_stat;

endpackage

[sv/sorted_priority_queue.sv]
// Channel   Direction  Transfer when          Signals
// command   in         start && !busy         i_kind, i_item_handle, i_item_type,
//                                             i_priority_req
// result    out        o_done (one cycle)     o_status, o_entry_count, o_out_handle,
//                                             o_out_type, o_out_priority
//
// A remove reads the head entry and then takes it; a remove from an empty queue goes straight
// to the result. An insert walks the stored entries and then moves the entries behind its
// place, as each entry checked or moved costs an address and a data step; a rejected insert
// ends where the check fails. The next command is taken the cycle after the result strobe.
// Reset is synchronous and active low; it empties the queue and leaves the store as it is.
// The receiver cannot stall: each result strobe is high for exactly one cycle.

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic [15:0]        i_item_handle,
    input  logic [7:0]         i_item_type,
    input  logic signed [15:0] i_priority_req,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [4:0]         o_entry_count,
    output logic [15:0]        o_out_handle,
    output logic [7:0]         o_out_type,
    output logic signed [15:0] o_out_priority
);

    // The entries live in a circular store addressed from a head pointer, so a
    // removal only advances the head and never moves data. An insertion first
    // walks the whole queue to check the handle against every stored entry and
    // to find the first entry with a strictly greater priority value; placing
    // the new entry there keeps entries of equal priority in arrival order.
    // The entries from that point to the tail are then copied up one place,
    // starting at the tail, and the new entry is written into the gap.

    spq_pkg::t_dp_cmd  cmd;
    spq_pkg::t_dp_stat stat;

    // The controller sequences the scan, shift and write steps.
    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // The datapath holds the store, the pointers and the result registers.
    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_item_handle  (i_item_handle),
        .i_item_type    (i_item_type),
        .i_priority_req (i_priority_req),
        .o_stat         (stat),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_out_handle   (o_out_handle),
        .o_out_type     (o_out_type),
        .o_out_priority (o_out_priority)
    );

endmodule

[sv/spq_ram.sv]
module spq_ram #(
    parameter int WIDTH = spq_pkg::ENTRY_W,
    parameter int DEPTH = spq_pkg::QUEUE_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/spq_datapath.sv]
`include "assert_macros.svh"

module spq_datapath #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH,
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_dp_cmd   i_cmd,
    input  logic [15:0]        i_item_handle,
    input  logic [7:0]         i_item_type,
    input  logic signed [15:0] i_priority_req,
    output spq_pkg::t_dp_stat  o_stat,
    output logic [1:0]         o_status,
    output logic [4:0]         o_entry_count,
    output logic [15:0]        o_out_handle,
    output logic [7:0]         o_out_type,
    output logic signed [15:0] o_out_priority
);

    localparam int SW  = CW + 1;
    localparam int AW1 = AW + 1;
    localparam logic [SW-1:0]  DEPTH_S  = SW'(QUEUE_DEPTH);
    localparam logic [AW1-1:0] HEAD_LIM = AW1'(QUEUE_DEPTH);
    localparam logic [CW-1:0]  DEPTH_C  = CW'(QUEUE_DEPTH);

    // Logical position to physical address in the circular store.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                            input logic [CW-1:0] lidx);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(lidx);
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_pos, n_pos;
    logic               r_found, n_found;
    logic [15:0]        r_req_handle, n_req_handle;
    logic [7:0]         r_req_type, n_req_type;
    logic signed [15:0] r_req_prio, n_req_prio;
    spq_pkg::t_status   r_status, n_status;
    logic [15:0]        r_out_handle, n_out_handle;
    logic [7:0]         r_out_type, n_out_type;
    logic [15:0]        r_out_prio, n_out_prio;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    logic [spq_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [spq_pkg::ENTRY_W-1:0]  ram_rdata;
    spq_pkg::t_entry              rd_entry;
    spq_pkg::t_entry              new_entry;
    logic [CW-1:0]                idx_m1;
    logic [AW1-1:0]               head_ext;
    logic [AW1-1:0]               head_p1;
    logic [CW+4:0]                count_ext;
    logic                         prio_gt;

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry  = spq_pkg::t_entry'(ram_rdata);
    assign idx_m1    = r_idx - CW'(1);
    assign head_ext  = {1'b0, r_head};
    assign head_p1   = head_ext + AW1'(1);
    assign prio_gt   = $signed(rd_entry.prio) > r_req_prio;

    always_comb begin
        new_entry.handle    = r_req_handle;
        new_entry.item_type = r_req_type;
        new_entry.prio      = r_req_prio;
    end

    assign ram_raddr = i_cmd.rd_prev ? phys(r_head, idx_m1) : phys(r_head, r_idx);
    assign ram_waddr = phys(r_head, r_idx);
    assign ram_we    = i_cmd.shift_write | i_cmd.ins_write;
    assign ram_wdata = i_cmd.ins_write ? new_entry : ram_rdata;

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.full       = (r_count == DEPTH_C);
    assign o_stat.dup        = (rd_entry.handle == r_req_handle);
    assign o_stat.scan_last  = ((SW'(r_idx) + SW'(1)) == SW'(r_count));
    assign o_stat.shift_done = (r_idx == r_pos);

    always_comb begin
        n_count      = r_count;
        n_head       = r_head;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_found      = r_found;
        n_req_handle = r_req_handle;
        n_req_type   = r_req_type;
        n_req_prio   = r_req_prio;
        n_status     = r_status;
        n_out_handle = r_out_handle;
        n_out_type   = r_out_type;
        n_out_prio   = r_out_prio;

        if (i_cmd.accept) begin
            n_req_handle = i_item_handle;
            n_req_type   = i_item_type;
            n_req_prio   = i_priority_req;
            n_idx        = '0;
            n_pos        = r_count;
            n_found      = 1'b0;
        end
        if (i_cmd.scan_check) begin
            if (prio_gt && !r_found) begin
                n_pos   = r_idx;
                n_found = 1'b1;
            end
            n_idx = r_idx + CW'(1);
        end
        if (i_cmd.shift_write) begin
            n_idx = idx_m1;
        end
        if (i_cmd.ins_write) begin
            n_count = r_count + CW'(1);
        end
        if (i_cmd.take_head) begin
            n_count = r_count - CW'(1);
            n_head  = (head_p1 == HEAD_LIM) ? '0 : head_p1[AW-1:0];
        end
        if (i_cmd.set_res) begin
            n_status = i_cmd.res_code;
            if (i_cmd.take_head) begin
                n_out_handle = rd_entry.handle;
                n_out_type   = rd_entry.item_type;
                n_out_prio   = rd_entry.prio;
            end else begin
                n_out_handle = '0;
                n_out_type   = '0;
                n_out_prio   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_head  <= '0;
            r_idx   <= '0;
            r_pos   <= '0;
            r_found <= 1'b0;
        end else begin
            r_count <= n_count;
            r_head  <= n_head;
            r_idx   <= n_idx;
            r_pos   <= n_pos;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_handle <= n_req_handle;
        r_req_type   <= n_req_type;
        r_req_prio   <= n_req_prio;
        r_status     <= n_status;
        r_out_handle <= n_out_handle;
        r_out_type   <= n_out_type;
        r_out_prio   <= n_out_prio;
    end

    assign count_ext      = {5'b0, r_count};
    assign o_entry_count  = count_ext[4:0];
    assign o_status       = r_status;
    assign o_out_handle   = r_out_handle;
    assign o_out_type     = r_out_type;
    assign o_out_priority = r_out_prio;

    `SPQ_ASSERT(a_count_bound, r_count <= DEPTH_C, "entry count beyond queue depth")
    `SPQ_ASSERT(a_head_bound, head_ext < HEAD_LIM, "head pointer outside the store")
    `SPQ_ASSERT_NEVER(a_ins_full, i_cmd.ins_write && o_stat.full, "insert into a full queue")
    `SPQ_ASSERT_NEVER(a_rm_empty, i_cmd.take_head && o_stat.count_zero,
        "head taken from an empty queue")

endmodule

[sv/spq_ctrl.sv]
`include "assert_macros.svh"

module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_kind,
    input  spq_pkg::t_dp_stat i_stat,
    output spq_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_done
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SCAN_RD = 9'b000000010,
        S_SCAN_CK = 9'b000000100,
        S_SH_RD   = 9'b000001000,
        S_SH_WR   = 9'b000010000,
        S_INS_WR  = 9'b000100000,
        S_RM_RD   = 9'b001000000,
        S_RM_LAT  = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    case (i_kind)
                        spq_pkg::KIND_REMOVE: begin
                            if (i_stat.count_zero) begin
                                o_cmd.set_res  = 1'b1;
                                o_cmd.res_code = spq_pkg::ST_EMPTY;
                                n_state        = S_DONE;
                            end else begin
                                n_state = S_RM_RD;
                            end
                        end
                        spq_pkg::KIND_INSERT: begin
                            n_state = i_stat.count_zero ? S_SH_RD : S_SCAN_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                o_cmd.scan_check = 1'b1;
                if (i_stat.dup) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = spq_pkg::ST_DUP;
                    n_state        = S_DONE;
                end else if (i_stat.scan_last) begin
                    if (i_stat.full) begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = spq_pkg::ST_FULL;
                        n_state        = S_DONE;
                    end else begin
                        n_state = S_SH_RD;
                    end
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SH_RD: begin
                if (i_stat.shift_done) begin
                    n_state = S_INS_WR;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.shift_write = 1'b1;
                n_state           = S_SH_RD;
            end
            S_INS_WR: begin
                o_cmd.ins_write = 1'b1;
                o_cmd.set_res   = 1'b1;
                o_cmd.res_code  = spq_pkg::ST_OK;
                n_state         = S_DONE;
            end
            S_RM_RD: begin
                n_state = S_RM_LAT;
            end
            S_RM_LAT: begin
                o_cmd.take_head = 1'b1;
                o_cmd.set_res   = 1'b1;
                o_cmd.res_code  = spq_pkg::ST_OK;
                n_state         = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    `SPQ_ASSERT(a_accept_busy, i_start && !o_busy |=> o_busy, "accepted command left block idle")
    `SPQ_ASSERT(a_done_idle, o_done |=> !o_busy, "block still busy after result strobe")
    `SPQ_ASSERT_NEVER(a_two_writes, o_cmd.shift_write && o_cmd.ins_write,
        "two store writes in one cycle")

endmodule
